>>> rtl/bkc_pkg.sv
// ----------------------------------------------------------------------------
// bkc_pkg
// shared constants and types of the block keyed byte stream cipher
// ----------------------------------------------------------------------------
package bkc_pkg;

  // bytes per key block
  localparam int BLOCK_BYTES = 512;

  // byte position counter width and its last value
  localparam int                POS_W    = $clog2(BLOCK_BYTES);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(BLOCK_BYTES - 1);

  // key seed pattern at each block start
  localparam logic [15:0] SEED_XOR = 16'h484A;

  // block position status handed to the key logic
  typedef struct packed {
    logic        seed;       // first byte of a block, key gets reseeded
    logic [15:0] block_num;  // block number that applies to this byte
  } pos_status_t;

endpackage

>>> rtl/bkc_pos.sv
// ----------------------------------------------------------------------------
// bkc_pos
// byte position and block number counters
// ----------------------------------------------------------------------------
module bkc_pos
  import bkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,        // one byte processed this cycle
  input  logic        sos,        // start of stream flag of that byte
  output pos_status_t status
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      block_r, block_nxt;
  logic [POS_W-1:0] pos_eff;
  logic [15:0]      block_eff;

  // start of stream clears both counters before the byte
  assign pos_eff   = sos ? '0 : pos_r;
  assign block_eff = sos ? '0 : block_r;

  assign status = '{seed: (pos_eff == '0), block_num: block_eff};

  always_comb begin
    pos_nxt   = pos_r;
    block_nxt = block_r;
    if (adv) begin
      if (pos_eff == POS_LAST) begin
        pos_nxt   = '0;
        block_nxt = block_eff + 16'd1;
      end else begin
        pos_nxt   = pos_eff + POS_W'(1);
        block_nxt = block_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      block_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      block_r <= block_nxt;
    end
  end

  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position beyond block end");

  a_sos_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && sos) |=> (pos_r == POS_W'(1)) && (block_r == 16'd0))
    else $error("start of stream did not restart the counters");

endmodule

>>> rtl/bkc_keygen.sv
// ----------------------------------------------------------------------------
// bkc_keygen
// keystream selection, byte xor and next key computation
// ----------------------------------------------------------------------------
module bkc_keygen
  import bkc_pkg::*;
(
  input  logic [15:0]  key_in,
  input  pos_status_t  status,
  input  logic [7:0]   data_byte,
  input  logic         decode_mode,
  output logic [7:0]   out_byte,
  output logic [15:0]  key_out
);

  logic [15:0] key_cur;
  logic [7:0]  ks;
  logic [7:0]  cbyte;
  logic [15:0] k;        // upper half of the 32 bit feedback word
  logic        x31, x30, x26, x25, x23;

  assign key_cur = status.seed ? (status.block_num ^ SEED_XOR) : key_in;

  assign ks = {key_cur[14], key_cur[12], key_cur[11], key_cur[9],
               key_cur[7],  key_cur[6],  key_cur[1],  key_cur[0]};

  assign out_byte = data_byte ^ ks;
  assign cbyte    = decode_mode ? data_byte : out_byte;

  assign k = {cbyte, 8'h00} ^ key_cur;

  // suffix xors of the word, only the bits used below
  assign x31 = k[15];
  assign x30 = ^k[15:14];
  assign x26 = ^k[15:10];
  assign x25 = ^k[15:9];
  assign x23 = ^k[15:7];

  assign key_out = {x23,
                    k[6], k[5], k[4], k[3], k[2],
                    k[1] ^ x31, k[0] ^ x30,
                    k[14] ^ k[13], k[13] ^ k[12], k[12] ^ k[11],
                    k[11] ^ k[10], k[10] ^ k[9], k[9] ^ k[8],
                    k[9] ^ x26, k[8] ^ x25};

endmodule

>>> rtl/block_keyed_byte_stream_cipher.sv
// ----------------------------------------------------------------------------
// block_keyed_byte_stream_cipher
// byte stream cipher with block keyed seed and ciphertext feedback
// ----------------------------------------------------------------------------
// Each input byte is XORed with a keystream byte taken from a 16-bit running
// key, and the key is then advanced from the ciphertext byte. The key is
// reseeded as block number XOR 0x484A at the first byte of every block of
// BLOCK_BYTES bytes, and a byte with start_of_stream set restarts block and
// byte counting before it is processed. One byte is taken per clock while
// out_stall is low: a byte is held in the input register, the key update and
// output XOR are combinational XOR logic, and the result lands in the output
// register, which drives out_valid; throughput is one byte per cycle while
// out_stall is low. The input stalls only while the output register holds
// an untaken byte and a second byte waits in the input register. decode_mode
// (written through the cfg port, always ready) picks the feedback source and
// must only change while idle.
// ----------------------------------------------------------------------------
module block_keyed_byte_stream_cipher
  import bkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_stream,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_decode_mode
);

  // input register
  logic        s1_vld_r, s1_vld_nxt;
  logic [7:0]  s1_data_r;
  logic        s1_sos_r;

  // output register
  logic        out_vld_r, out_vld_nxt;
  logic [7:0]  out_byte_r;

  // running key and mode
  logic [15:0] key_r;
  logic        decode_mode_r;

  logic        adv;        // input register byte moves to output register
  logic        in_xfer;    // input transfer
  logic        out_xfer;   // result transfer
  pos_status_t pos_status;
  logic [7:0]  calc_byte;
  logic [15:0] key_next;

  assign out_xfer = out_vld_r && !out_stall;
  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  // input register frees up when its byte moves on
  assign in_stall = s1_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;

  bkc_pos u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .sos    (s1_sos_r),
    .status (pos_status)
  );

  bkc_keygen u_keygen (
    .key_in      (key_r),
    .status      (pos_status),
    .data_byte   (s1_data_r),
    .decode_mode (decode_mode_r),
    .out_byte    (calc_byte),
    .key_out     (key_next)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_xfer) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      key_r         <= '0;
      decode_mode_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        key_r <= key_next;
      end
      if (cfg_valid && cfg_ready) begin
        decode_mode_r <= cfg_decode_mode;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data_byte;
      s1_sos_r  <= in_start_of_stream;
    end
    if (adv) begin
      out_byte_r <= calc_byte;
    end
  end

  a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed byte did not reach the output register");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !adv) |=> s1_vld_r && $stable(s1_data_r) && $stable(s1_sos_r))
    else $error("waiting input byte was lost or changed");

  a_key_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(key_r))
    else $error("key changed without a processed byte");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the block keyed byte stream cipher
// ----------------------------------------------------------------------------
// Streams of bytes are queued by a stimulus process and sent by a driver that
// inserts random gaps, while the result side stalls at random. Every accepted
// byte is run through a local cipher model that keeps its own key, byte
// position, block number and feedback mode. The predicted bytes are compared
// in order with the bytes that leave the block. Both feedback modes are used,
// and some streams are long enough to cross block boundaries.
// ----------------------------------------------------------------------------
module testbench
  import bkc_pkg::*;
();

  typedef struct packed {
    logic [7:0] data;
    logic       sos;
  } byte_item_t;

  logic       clk                = 1'b0;
  logic       rst_n              = 1'b0;
  logic       in_valid           = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte       = 8'h00;
  logic       in_start_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall          = 1'b0;
  logic [7:0] out_byte;
  logic       cfg_valid          = 1'b0;
  logic       cfg_ready;
  logic       cfg_decode_mode    = 1'b0;

  block_keyed_byte_stream_cipher dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_stream (in_start_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_decode_mode    (cfg_decode_mode)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // generous limit, far above the slowest legal run
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

  // cipher model state
  logic [15:0]      model_key    = 16'h0000;
  logic [POS_W-1:0] model_pos    = '0;
  logic [15:0]      model_block  = 16'h0000;
  logic             model_decode = 1'b0;

  byte_item_t pending_bytes[$];
  logic [7:0] expected_bytes[$];

  byte_item_t next_item;
  logic [7:0] want_byte;
  bit         byte_taken = 1'b0;
  int         gap_left   = 0;
  int         send_calm  = 0;
  int         stall_left = 0;
  int         stall_calm = 0;

  int error_count    = 0;
  int bytes_queued   = 0;
  int bytes_accepted = 0;
  int bytes_decoded  = 0;
  int stream_starts  = 0;
  int block_rolls    = 0;
  int mode_writes    = 0;

  // one step of the ciphertext feedback: k holds {cbyte ^ key_hi, key_lo}
  // in bits 31..16, x[i] is the xor of k[31:i]
  function automatic logic [15:0] advance_key(logic [7:0] cbyte, logic [15:0] key);
    logic [31:0] k;
    logic [31:0] x;
    logic        acc;
    k   = {({cbyte, 8'h00} ^ key), 16'h0000};
    acc = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      acc  = acc ^ k[i];
      x[i] = acc;
    end
    return {x[23], k[22:18], k[17] ^ x[31], k[16] ^ x[30],
            k[30] ^ k[29], k[29] ^ k[28], k[28] ^ k[27], k[27] ^ k[26],
            k[26] ^ k[25], k[25] ^ k[24], k[25] ^ x[26], k[24] ^ x[25]};
  endfunction

  // encrypt or decrypt one accepted byte and advance the model state
  function automatic logic [7:0] cipher_byte(logic [7:0] din, logic sos);
    logic [7:0] keystream;
    logic [7:0] dout;
    if (sos) begin
      model_pos   = '0;
      model_block = 16'h0000;
      stream_starts++;
    end
    // reseed on the first byte of every block
    if (model_pos == '0) model_key = model_block ^ SEED_XOR;
    keystream = {model_key[14], model_key[12], model_key[11], model_key[9],
                 model_key[7], model_key[6], model_key[1], model_key[0]};
    dout      = din ^ keystream;
    model_key = advance_key(model_decode ? din : dout, model_key);
    if (model_pos == POS_LAST) begin
      model_pos   = '0;
      model_block = model_block + 16'd1;
      block_rolls++;
    end else begin
      model_pos = model_pos + POS_W'(1);
    end
    if (model_decode) bytes_decoded++;
    return dout;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // gap or stall length: mostly none or short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // input driver: a byte stays on the port until its transfer is seen
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !byte_taken) begin
        // stalled transfer, payload held
      end else begin
        byte_taken = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          in_data_byte       <= next_item.data;
          in_start_of_stream <= next_item.sos;
          in_valid           <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            gap_left = idle_length();
            if ($urandom_range(0, 149) == 0) send_calm = $urandom_range(40, 200);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back pressure, with calm stretches in between
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (stall_calm > 0) begin
        stall_calm--;
      end else begin
        stall_left = idle_length();
        if ($urandom_range(0, 149) == 0) stall_calm = $urandom_range(40, 200);
      end
    end
  end

  // monitor: checks results in order and predicts each accepted byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing outstanding", out_byte));
        end else begin
          want_byte = expected_bytes.pop_front();
          if (out_byte !== want_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want_byte));
        end
      end
      if (in_valid && !in_stall) begin
        expected_bytes.push_back(cipher_byte(in_data_byte, in_start_of_stream));
        byte_taken = 1'b1;
        bytes_accepted++;
      end
    end
  end

  task automatic queue_byte(logic [7:0] data, logic sos);
    byte_item_t item;
    item.data = data;
    item.sos  = sos;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  // one stream of random bytes, restarted or continuing the current one, with rare restarts mid-stream
  task automatic queue_stream(int len, bit restart);
    for (int i = 0; i < len; i++) begin
      if (i == 0) queue_byte(8'($urandom_range(0, 255)), restart);
      else queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 199) == 0);
    end
  endtask

  // edge bytes, restarts mid-stream, and a first byte without a restart
  task automatic queue_directed();
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hFE, 1'b1);
  endtask

  // sender holds off until every byte is through and the pipe is empty
  task automatic wait_drained();
    @(negedge clk);
    while (bytes_accepted != bytes_queued || expected_bytes.size() != 0 || in_valid)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_decode_mode(logic mode);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_decode_mode <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_decode = mode;
    mode_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [5:0] phase_modes;
    int         phase_bytes;
    int         len;
    phase_modes = 6'b010110;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed bytes, encoding first, then decoding
    set_decode_mode(1'b0);
    queue_directed();
    wait_drained();
    set_decode_mode(1'b1);
    queue_directed();

    // random phases, each under its own feedback mode
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      set_decode_mode(phase_modes[ph]);
      phase_bytes = 0;
      // two long streams run across one and two block boundaries
      if (ph == 1) begin
        len = $urandom_range(BLOCK_BYTES + 10, BLOCK_BYTES + 180);
        queue_stream(len, 1'b1);
        phase_bytes += len;
      end else if (ph == 2) begin
        len = $urandom_range(2 * BLOCK_BYTES + 5, 2 * BLOCK_BYTES + 80);
        queue_stream(len, 1'b1);
        phase_bytes += len;
      end
      while (phase_bytes < 40) begin
        if ($urandom_range(0, 99) < 75) len = $urandom_range(1, 24);
        else len = $urandom_range(25, 120);
        queue_stream(len, $urandom_range(0, 99) < 85);
        phase_bytes += len;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes (%0d decoded) in %0d streams, %0d block rolls",
             bytes_accepted, bytes_decoded, stream_starts, block_rolls);
    $display("feedback mode written %0d times, %0d mismatches", mode_writes, error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bkc_pkg.sv
rtl/bkc_pos.sv
rtl/bkc_keygen.sv
rtl/block_keyed_byte_stream_cipher.sv
tb/sv/testbench.sv
